/* hdl/triangle_quality_histogram_macros.svh */
// Assertion macros shared by the triangle quality histogram RTL.
`ifndef TRIANGLE_QUALITY_HISTOGRAM_MACROS_SVH
`define TRIANGLE_QUALITY_HISTOGRAM_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TQH_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TQH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/tqh_pkg.sv */
// Types, widths and constants shared by the triangle quality histogram.
package tqh_pkg;

   localparam int COORD_WIDTH     = 24;
   localparam int COUNT_WIDTH     = 32;
   localparam int RATIO_FRAC_BITS = 16;

   localparam int NUM_BINS   = 10;
   localparam int BIN_W      = 4;
   localparam int THR_STEP   = 10000;
   localparam int THR_BIAS   = 1;
   localparam int THR_SCALE  = 100000;

   // Edge components, multiplier operands and products.
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int MUL_W  = DIFF_W + 1;
   localparam int PROD_W = 2 * MUL_W;
   localparam int CR_W   = PROD_W + 1;
   localparam int MAG_W  = 2 * DIFF_W;

   // Sum of squared sides, squared cross product, root operand and root.
   localparam int S_W    = 2 * COORD_WIDTH + 4;
   localparam int X_W    = 4 * COORD_WIDTH + 4;
   localparam int N_W    = X_W + 4 + 2 * RATIO_FRAC_BITS;
   localparam int Y_W    = N_W / 2;
   localparam int REM_W  = Y_W + 3;
   localparam int Q_W    = RATIO_FRAC_BITS + 1;
   localparam int ITER_W = $clog2(Y_W + 1);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] ax;
      logic signed [COORD_WIDTH-1:0] ay;
      logic signed [COORD_WIDTH-1:0] az;
      logic signed [COORD_WIDTH-1:0] bx;
      logic signed [COORD_WIDTH-1:0] by_coord;
      logic signed [COORD_WIDTH-1:0] bz;
      logic signed [COORD_WIDTH-1:0] cx;
      logic signed [COORD_WIDTH-1:0] cy;
      logic signed [COORD_WIDTH-1:0] cz;
      logic                          last_triangle;
   } tqh_req_type;

   typedef struct packed {
      logic [BIN_W-1:0]       bin_index;
      logic [COUNT_WIDTH-1:0] bin_count;
      logic                   last_bin;
   } tqh_rsp_type;

   // Upper edge of bin k-1 in ratio units, worked out at elaboration.
   function automatic logic [Q_W-1:0] bin_threshold(input int k);
      logic [63:0] t;
      t = ((64'(THR_STEP) * 64'(k) + 64'(THR_BIAS)) << RATIO_FRAC_BITS) / THR_SCALE;
      return Q_W'(t);
   endfunction

endpackage

/* hdl/tqh_mac.sv */
// Shared multiplier sequence that forms the sum of squared sides and the squared cross product.
module tqh_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  tqh_pkg::tqh_req_type          vert,
   output logic                          done,
   output logic [tqh_pkg::S_W-1:0]       sum_sq,
   output logic [tqh_pkg::X_W-1:0]       cross_sq
);

   localparam int STEP_W    = 5;
   localparam int LAST_STEP = 27;

   localparam logic [2:0] K_NONE = 3'd0;
   localparam logic [2:0] K_SQ   = 3'd1;
   localparam logic [2:0] K_LOAD = 3'd2;
   localparam logic [2:0] K_SUB  = 3'd3;
   localparam logic [2:0] K_LL   = 3'd4;
   localparam logic [2:0] K_HL   = 3'd5;
   localparam logic [2:0] K_HH   = 3'd6;

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [STEP_W-1:0]                     step_ff, step_in;
   logic [2:0]                            kind_ff, kind_in, kind_dec;
   logic signed [tqh_pkg::DIFF_W-1:0]     diff_ff [9];
   logic signed [tqh_pkg::DIFF_W-1:0]     diff_in [9];
   logic signed [tqh_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic signed [tqh_pkg::CR_W-1:0]       cr_ff, cr_in;
   logic [tqh_pkg::S_W-1:0]               s_ff, s_in;
   logic [tqh_pkg::X_W-1:0]               x_ff, x_in;
   logic signed [tqh_pkg::MUL_W-1:0]      op_a, op_b, lo_op, hi_op;
   logic [tqh_pkg::CR_W-1:0]              cr_mag;
   logic [tqh_pkg::PROD_W-1:0]            prod_u;

   // Edge vectors e1 = B-A, e2 = C-A, e3 = C-B, taken at the input transfer.
   always_comb begin
      diff_in[0] = tqh_pkg::DIFF_W'(vert.bx)       - tqh_pkg::DIFF_W'(vert.ax);
      diff_in[1] = tqh_pkg::DIFF_W'(vert.by_coord) - tqh_pkg::DIFF_W'(vert.ay);
      diff_in[2] = tqh_pkg::DIFF_W'(vert.bz)       - tqh_pkg::DIFF_W'(vert.az);
      diff_in[3] = tqh_pkg::DIFF_W'(vert.cx)       - tqh_pkg::DIFF_W'(vert.ax);
      diff_in[4] = tqh_pkg::DIFF_W'(vert.cy)       - tqh_pkg::DIFF_W'(vert.ay);
      diff_in[5] = tqh_pkg::DIFF_W'(vert.cz)       - tqh_pkg::DIFF_W'(vert.az);
      diff_in[6] = tqh_pkg::DIFF_W'(vert.cx)       - tqh_pkg::DIFF_W'(vert.bx);
      diff_in[7] = tqh_pkg::DIFF_W'(vert.cy)       - tqh_pkg::DIFF_W'(vert.by_coord);
      diff_in[8] = tqh_pkg::DIFF_W'(vert.cz)       - tqh_pkg::DIFF_W'(vert.bz);
   end

   // Halves of the current cross component's magnitude feed its square.
   always_comb begin
      cr_mag = (cr_ff < 0) ? tqh_pkg::CR_W'(-cr_ff) : tqh_pkg::CR_W'(cr_ff);
      lo_op  = $signed({1'b0, cr_mag[tqh_pkg::DIFF_W-1:0]});
      hi_op  = $signed({1'b0, cr_mag[tqh_pkg::MAG_W-1:tqh_pkg::DIFF_W]});
   end

   // Operand schedule: nine squared edge components, then three groups of
   // two cross products, a bubble, and the three partial squares.
   always_comb begin
      op_a     = '0;
      op_b     = '0;
      kind_dec = K_NONE;
      case (step_ff) inside
         [0:8]: begin
            op_a     = tqh_pkg::MUL_W'(diff_ff[step_ff[3:0]]);
            op_b     = tqh_pkg::MUL_W'(diff_ff[step_ff[3:0]]);
            kind_dec = K_SQ;
         end
         9: begin
            op_a = tqh_pkg::MUL_W'(diff_ff[1]); op_b = tqh_pkg::MUL_W'(diff_ff[5]);
            kind_dec = K_LOAD;
         end
         10: begin
            op_a = tqh_pkg::MUL_W'(diff_ff[2]); op_b = tqh_pkg::MUL_W'(diff_ff[4]);
            kind_dec = K_SUB;
         end
         15: begin
            op_a = tqh_pkg::MUL_W'(diff_ff[2]); op_b = tqh_pkg::MUL_W'(diff_ff[3]);
            kind_dec = K_LOAD;
         end
         16: begin
            op_a = tqh_pkg::MUL_W'(diff_ff[0]); op_b = tqh_pkg::MUL_W'(diff_ff[5]);
            kind_dec = K_SUB;
         end
         21: begin
            op_a = tqh_pkg::MUL_W'(diff_ff[0]); op_b = tqh_pkg::MUL_W'(diff_ff[4]);
            kind_dec = K_LOAD;
         end
         22: begin
            op_a = tqh_pkg::MUL_W'(diff_ff[1]); op_b = tqh_pkg::MUL_W'(diff_ff[3]);
            kind_dec = K_SUB;
         end
         12, 18, 24: begin
            op_a = lo_op; op_b = lo_op; kind_dec = K_LL;
         end
         13, 19, 25: begin
            op_a = hi_op; op_b = lo_op; kind_dec = K_HL;
         end
         14, 20, 26: begin
            op_a = hi_op; op_b = hi_op; kind_dec = K_HH;
         end
         default: begin
            kind_dec = K_NONE;
         end
      endcase
   end

   // One registered multiply per cycle.
   always_comb begin
      prod_in = op_a * op_b;
      prod_u  = $unsigned(prod_ff);
   end

   // Accumulate the product registered in the previous cycle; a start clears both sums.
   always_comb begin
      s_in  = s_ff;
      x_in  = x_ff;
      cr_in = cr_ff;
      case (kind_ff)
         K_SQ:    s_in  = s_ff + tqh_pkg::S_W'(prod_u);
         K_LOAD:  cr_in = tqh_pkg::CR_W'(prod_ff);
         K_SUB:   cr_in = cr_ff - tqh_pkg::CR_W'(prod_ff);
         K_LL:    x_in  = x_ff + tqh_pkg::X_W'(prod_u[tqh_pkg::MAG_W-1:0]);
         K_HL:    x_in  = x_ff + (tqh_pkg::X_W'(prod_u[tqh_pkg::MAG_W-1:0])
                                  << (tqh_pkg::DIFF_W + 1));
         K_HH:    x_in  = x_ff + (tqh_pkg::X_W'(prod_u[tqh_pkg::MAG_W-1:0])
                                  << tqh_pkg::MAG_W);
         default: s_in  = s_ff;
      endcase
      if (start) begin
         s_in = '0;
         x_in = '0;
      end
   end

   // Step sequencing.
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      done_in = 1'b0;
      kind_in = busy_ff ? kind_dec : K_NONE;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         kind_in = K_NONE;
      end else if (busy_ff) begin
         if (step_ff == STEP_W'(LAST_STEP)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         kind_ff <= K_NONE;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         kind_ff <= kind_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         for (int i = 0; i < 9; i++) begin
            diff_ff[i] <= diff_in[i];
         end
      end
      prod_ff <= prod_in;
      cr_ff   <= cr_in;
      s_ff    <= s_in;
      x_ff    <= x_in;
   end

   assign done     = done_ff;
   assign sum_sq   = s_ff;
   assign cross_sq = x_ff;

endmodule

/* hdl/tqh_ratio.sv */
// Bit-serial square root and restoring divide that yield the quantized quality ratio.
module tqh_ratio (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tqh_pkg::S_W-1:0]       sum_sq,
   input  logic [tqh_pkg::X_W-1:0]       cross_sq,
   output logic                          done,
   output logic [tqh_pkg::Q_W-1:0]       ratio_q
);

   localparam logic [1:0] P_IDLE = 2'd0;
   localparam logic [1:0] P_ROOT = 2'd1;
   localparam logic [1:0] P_DIV  = 2'd2;

   logic [1:0]                        phase_ff, phase_in;
   logic [tqh_pkg::ITER_W-1:0]        iter_ff, iter_in;
   logic                              done_ff, done_in;
   logic                              zero_ff, zero_in;
   logic [tqh_pkg::N_W-1:0]           nsh_ff, nsh_in;
   logic [tqh_pkg::Y_W-1:0]           y_ff, y_in;
   logic [tqh_pkg::REM_W-1:0]         r_ff, r_in;
   logic [tqh_pkg::Y_W-1:0]           dv_ff, dv_in;
   logic [tqh_pkg::Q_W-1:0]           q_ff, q_in;
   logic [tqh_pkg::X_W+3:0]           x12;
   logic [tqh_pkg::REM_W-1:0]         r_sh, trial, dv_ext;
   logic                              root_ge, div_ge;

   // Root step takes two operand bits; divide step yields one quotient bit.
   always_comb begin
      x12     = ((tqh_pkg::X_W+4)'(cross_sq) << 3) + ((tqh_pkg::X_W+4)'(cross_sq) << 2);
      r_sh    = {r_ff[tqh_pkg::REM_W-3:0], nsh_ff[tqh_pkg::N_W-1 -: 2]};
      trial   = tqh_pkg::REM_W'({y_ff, 2'b01});
      root_ge = (r_sh >= trial);
      dv_ext  = tqh_pkg::REM_W'(dv_ff);
      div_ge  = (r_ff >= dv_ext);
   end

   always_comb begin
      phase_in = phase_ff;
      iter_in  = iter_ff;
      done_in  = 1'b0;
      zero_in  = zero_ff;
      nsh_in   = nsh_ff;
      y_in     = y_ff;
      r_in     = r_ff;
      dv_in    = dv_ff;
      q_in     = q_ff;
      case (phase_ff)
         P_IDLE: begin
            if (start) begin
               phase_in = P_ROOT;
               iter_in  = tqh_pkg::ITER_W'(tqh_pkg::Y_W - 1);
               zero_in  = (sum_sq == '0);
               nsh_in   = {x12, {(2*tqh_pkg::RATIO_FRAC_BITS){1'b0}}};
               y_in     = '0;
               r_in     = '0;
               dv_in    = {sum_sq, {tqh_pkg::RATIO_FRAC_BITS{1'b0}}};
               q_in     = '0;
            end
         end
         P_ROOT: begin
            r_in   = root_ge ? (r_sh - trial) : r_sh;
            y_in   = {y_ff[tqh_pkg::Y_W-2:0], root_ge};
            nsh_in = nsh_ff << 2;
            if (iter_ff == '0) begin
               // Root complete: it becomes the dividend.
               phase_in = P_DIV;
               iter_in  = tqh_pkg::ITER_W'(tqh_pkg::RATIO_FRAC_BITS);
               r_in     = tqh_pkg::REM_W'(y_in);
            end else begin
               iter_in = iter_ff - 1'b1;
            end
         end
         P_DIV: begin
            r_in  = div_ge ? (r_ff - dv_ext) : r_ff;
            q_in  = {q_ff[tqh_pkg::Q_W-2:0], div_ge};
            dv_in = dv_ff >> 1;
            if (iter_ff == '0) begin
               phase_in = P_IDLE;
               done_in  = 1'b1;
            end else begin
               iter_in = iter_ff - 1'b1;
            end
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         done_ff  <= 1'b0;
         iter_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
         iter_ff  <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
      nsh_ff  <= nsh_in;
      y_ff    <= y_in;
      r_ff    <= r_in;
      dv_ff   <= dv_in;
      q_ff    <= q_in;
   end

   // A triangle with all vertices equal rates as zero.
   assign done    = done_ff;
   assign ratio_q = zero_ff ? '0 : q_ff;

endmodule

/* hdl/triangle_quality_histogram.sv */
// Top level of the triangle quality histogram: sequencing, bin counters and result dump.
//
//   Channel   Ports                              Direction  Moves
//   req       req_valid req_stall req_payload    in         one triangle per transfer
//   rsp       rsp_valid rsp_stall rsp_payload    out        one bin count per transfer
//
// After a transfer a triangle runs the multiplier sequence, then the root and divide unit (68 root,
// 17 quotient steps); it is counted when the ratio unit finishes, and then req reopens or a dump starts.
// A last triangle is followed by ten result transfers, one per cycle when rsp is not stalled.
// Reset is synchronous and clears the sequencer, the output valid flag and all counters.
// req_stall is high from a transfer until the triangle is counted and any dump is loaded.
// A stalled result holds in the output register; the next triangle may be taken meanwhile.
`include "triangle_quality_histogram_macros.svh"

module triangle_quality_histogram (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tqh_pkg::tqh_req_type   req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tqh_pkg::tqh_rsp_type   rsp_payload
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MAC   = 2'd1;
   localparam logic [1:0] ST_RATIO = 2'd2;
   localparam logic [1:0] ST_DUMP  = 2'd3;

   localparam logic [tqh_pkg::BIN_W-1:0] LAST_IDX = tqh_pkg::BIN_W'(tqh_pkg::NUM_BINS - 1);
   localparam logic [tqh_pkg::Q_W-1:0]   Q_MAX =
      tqh_pkg::Q_W'(1) << tqh_pkg::RATIO_FRAC_BITS;
   localparam logic [tqh_pkg::COUNT_WIDTH-1:0] CNT_MAX = '1;

   logic [1:0]                          state_ff, state_in;
   logic                                last_ff, last_in;
   logic [tqh_pkg::BIN_W-1:0]           idx_ff, idx_in;
   logic [tqh_pkg::COUNT_WIDTH-1:0]     cnt_ff [tqh_pkg::NUM_BINS];
   logic [tqh_pkg::COUNT_WIDTH-1:0]     cnt_in [tqh_pkg::NUM_BINS];
   logic                                rsp_valid_ff, rsp_valid_in;
   tqh_pkg::tqh_rsp_type                rsp_payload_ff, rsp_payload_in;
   logic                                req_take, dump_load, counters_zero;
   logic                                mac_done, ratio_done;
   logic [tqh_pkg::S_W-1:0]             sum_sq;
   logic [tqh_pkg::X_W-1:0]             cross_sq;
   logic [tqh_pkg::Q_W-1:0]             ratio_q;
   logic [tqh_pkg::BIN_W-1:0]           bin;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign dump_load = (state_ff == ST_DUMP) && (!rsp_valid_ff || !rsp_stall);

   tqh_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .start    (req_take),
      .vert     (req_payload),
      .done     (mac_done),
      .sum_sq   (sum_sq),
      .cross_sq (cross_sq)
   );

   tqh_ratio u_ratio (
      .clock    (clock),
      .reset    (reset),
      .start    (mac_done),
      .sum_sq   (sum_sq),
      .cross_sq (cross_sq),
      .done     (ratio_done),
      .ratio_q  (ratio_q)
   );

   // Bin number is how many thresholds the ratio exceeds.
   always_comb begin
      bin = '0;
      for (int k = 1; k < tqh_pkg::NUM_BINS; k++) begin
         if (ratio_q > tqh_pkg::bin_threshold(k)) begin
            bin = tqh_pkg::BIN_W'(k);
         end
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_MAC;
               last_in  = req_payload.last_triangle;
            end
         end
         ST_MAC: begin
            if (mac_done) begin
               state_in = ST_RATIO;
            end
         end
         ST_RATIO: begin
            if (ratio_done) begin
               state_in = last_ff ? ST_DUMP : ST_IDLE;
               idx_in   = '0;
            end
         end
         ST_DUMP: begin
            if (dump_load) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Saturating counters; a dump shifts them toward bin zero and fills with zero.
   always_comb begin
      for (int k = 0; k < tqh_pkg::NUM_BINS; k++) begin
         cnt_in[k] = cnt_ff[k];
         if (state_ff == ST_RATIO && ratio_done && bin == tqh_pkg::BIN_W'(k)
             && cnt_ff[k] != CNT_MAX) begin
            cnt_in[k] = cnt_ff[k] + 1'b1;
         end
         if (dump_load) begin
            cnt_in[k] = (k == tqh_pkg::NUM_BINS - 1) ? '0 : cnt_ff[(k + 1) % tqh_pkg::NUM_BINS];
         end
      end
   end

   // Output register for the result transfer.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (dump_load) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.bin_index = idx_ff;
         rsp_payload_in.bin_count = cnt_ff[0];
         rsp_payload_in.last_bin  = (idx_ff == LAST_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < tqh_pkg::NUM_BINS; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < tqh_pkg::NUM_BINS; k++) begin
            cnt_ff[k] <= cnt_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // All counters are clear.
   always_comb begin
      counters_zero = 1'b1;
      for (int k = 0; k < tqh_pkg::NUM_BINS; k++) begin
         if (cnt_ff[k] != '0) begin
            counters_zero = 1'b0;
         end
      end
   end

   // The ratio unit finishes only while the sequencer waits for it.
   `TQH_ASSERT_NOW(a_ratio_in_state, ratio_done, state_ff == ST_RATIO, "ratio done outside wait")
   // The ratio of a real triangle never exceeds one.
   `TQH_ASSERT_NOW(a_ratio_bound, ratio_done, ratio_q <= Q_MAX, "ratio above one")
   // After the last bin is loaded every counter is clear.
   `TQH_ASSERT_NEXT(a_dump_clears, dump_load && idx_ff == LAST_IDX, counters_zero, "dump left counts")

endmodule
